// ===== rtl/ntc_pt_pkg.sv =====
// ============================================================================
// ntc_pt_pkg
// Segment table for the NTC thermistor linearization: lower bounds, Q16
// slope and offset of each segment, quadratic term of the last segment.
// ============================================================================
package ntc_pt_pkg;

    localparam int RAW_W    = 12;   // adc sample width
    localparam int TEMP_W   = 9;    // signed degrees celsius
    localparam int FRAC_W   = 16;   // coefficient fraction bits
    localparam int ACC_W    = 36;   // accumulator, covers any table product
    localparam int COEF_W   = 21;   // signed slope width
    localparam int OFS_W    = 25;   // signed offset width
    localparam int SEGMENTS = 9;
    localparam int SEG_W    = $clog2(SEGMENTS);
    localparam int SQ_W     = 8;    // square of a 4-bit scaled value
    localparam int QUAD_W   = 16;

    localparam logic [RAW_W-1:0] SCALED_MIN = RAW_W'(5);
    localparam logic [RAW_W-1:0] SCALED_MAX = RAW_W'(483);

    // last segment: q*d*d + a*d + b, q = 0.5588 in Q16
    localparam logic [SEG_W-1:0]  SEG_QUAD  = SEG_W'(SEGMENTS - 1);
    localparam logic [QUAD_W-1:0] QUAD_COEF = QUAD_W'(36622);

    typedef logic [SEG_W-1:0]         seg_idx_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    // lower bound of each segment, highest first
    function automatic logic [RAW_W-1:0] seg_lower(input seg_idx_t k);
        logic [RAW_W-1:0] r;
        case (k)
            4'd0:    r = RAW_W'(424);
            4'd1:    r = RAW_W'(316);
            4'd2:    r = RAW_W'(195);
            4'd3:    r = RAW_W'(107);
            4'd4:    r = RAW_W'(56);
            4'd5:    r = RAW_W'(30);
            4'd6:    r = RAW_W'(17);
            4'd7:    r = RAW_W'(10);
            4'd8:    r = RAW_W'(5);
            default: r = RAW_W'(5);
        endcase
        return r;
    endfunction

    // linear coefficient, Q16
    function automatic logic signed [COEF_W-1:0] seg_slope(input seg_idx_t k);
        logic signed [COEF_W-1:0] r;
        case (k)
            4'd0:    r = -COEF_W'(21863);
            4'd1:    r = -COEF_W'(11960);
            4'd2:    r = -COEF_W'(10774);
            4'd3:    r = -COEF_W'(14903);
            4'd4:    r = -COEF_W'(26162);
            4'd5:    r = -COEF_W'(50928);
            4'd6:    r = -COEF_W'(98966);
            4'd7:    r = -COEF_W'(190756);
            4'd8:    r = -COEF_W'(923337);
            default: r = '0;
        endcase
        return r;
    endfunction

    // constant term, Q16
    function automatic logic signed [OFS_W-1:0] seg_offset(input seg_idx_t k);
        logic signed [OFS_W-1:0] r;
        case (k)
            4'd0:    r = OFS_W'(8035369);
            4'd1:    r = OFS_W'(3813343);
            4'd2:    r = OFS_W'(3399221);
            4'd3:    r = OFS_W'(4169925);
            4'd4:    r = OFS_W'(5344592);
            4'd5:    r = OFS_W'(6716785);
            4'd6:    r = OFS_W'(8146125);
            4'd7:    r = OFS_W'(9662628);
            4'd8:    r = OFS_W'(13413253);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ntc_piecewise_temperature.sv =====
// ============================================================================
// ntc_piecewise_temperature
// NTC 5k thermistor sample to signed whole degrees celsius by a nine-segment
// piecewise fit, four register stages.
// ============================================================================
// usage:
//   s_ channel carries one 12-bit adc sample per transaction; m_ channel
//   returns one result per sample, in order: temperature_c (signed, truncated
//   toward zero) and in_range. A scaled sample outside 5..483 gives
//   temperature 0 with in_range low.
// pipeline:
//   a sample is registered in each stage in turn and shows on m_ from the
//   output register. One sample per cycle is sustained while m_ready is
//   high. Stages: segment select, slope multiply and square, quadratic
//   multiply and sum, truncation into the output register. The stage-2
//   slope multiplier sets the clock period.
// reset:
//   aresetn clears every stage valid bit; no result is pending afterwards.
// stall:
//   while m_ready is low the output holds; upstream stages keep filling
//   bubbles, and s_ready drops only once all four stages hold a transaction.
// ============================================================================
module ntc_piecewise_temperature #(
    parameter int DIVIDER_SHIFT = 3
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [ntc_pt_pkg::RAW_W-1:0]             s_raw_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [ntc_pt_pkg::TEMP_W-1:0]     m_temperature_c,
    output logic                                     m_in_range
);
    import ntc_pt_pkg::*;

    localparam int DW = RAW_W - DIVIDER_SHIFT;   // scaled sample width
    localparam int QW = 24;                      // quadratic term width

    // stage advance chain
    logic adv1, adv2, adv3, adv4;

    // stage 1: scaled sample, segment, range flag
    logic           v1_reg, v1_next;
    logic [DW-1:0]  d1_reg, d1_next;
    seg_idx_t       k1_reg, k1_next;
    logic           rng1_reg, rng1_next;

    // stage 2: linear part and square
    logic           v2_reg, v2_next;
    acc_t           lin2_reg, lin2_next;
    logic [SQ_W-1:0] sq2_reg, sq2_next;
    logic           quad2_reg, quad2_next;
    logic           rng2_reg, rng2_next;

    // stage 3: full sum
    logic           v3_reg, v3_next;
    acc_t           acc3_reg, acc3_next;
    logic           rng3_reg, rng3_next;

    // stage 4: output register
    logic                     m_valid_reg, m_valid_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic                     rng4_reg, rng4_next;

    logic [RAW_W-1:0] d_ext;
    logic [QW-1:0]    sq_term;

    // a stage moves when it is empty or its successor moves
    assign adv4    = !m_valid_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    // stage 1: scale, range check, segment priority select
    always_comb begin
        d1_next   = s_raw_sample[RAW_W-1:DIVIDER_SHIFT];
        d_ext     = RAW_W'(d1_next);
        rng1_next = (d_ext >= SCALED_MIN) && (d_ext <= SCALED_MAX);
        k1_next   = SEG_QUAD;
        for (int i = SEGMENTS - 1; i >= 0; i--) begin
            if (d_ext >= seg_lower(SEG_W'(i))) begin
                k1_next = SEG_W'(i);
            end
        end
    end

    // stage 2: slope * d + offset, d squared for the last segment
    always_comb begin
        lin2_next  = ACC_W'(seg_slope(k1_reg)) * $signed({{(ACC_W-DW){1'b0}}, d1_reg})
                   + ACC_W'(seg_offset(k1_reg));
        sq2_next   = SQ_W'(d1_reg[3:0]) * SQ_W'(d1_reg[3:0]);
        quad2_next = (k1_reg == SEG_QUAD);
        rng2_next  = rng1_reg;
    end

    // stage 3: add quadratic term
    always_comb begin
        sq_term   = QW'(QUAD_COEF) * QW'(sq2_reg);
        acc3_next = lin2_reg + (quad2_reg ? $signed({{(ACC_W-QW){1'b0}}, sq_term})
                                          : ACC_W'(0));
        rng3_next = rng2_reg;
    end

    // stage 4: integer part toward zero (floor, plus one for negative with fraction)
    always_comb begin
        temp_next = acc3_reg[FRAC_W+TEMP_W-1:FRAC_W]
                  + TEMP_W'(acc3_reg[ACC_W-1] && (|acc3_reg[FRAC_W-1:0]));
        if (!rng3_reg) begin
            temp_next = '0;
        end
        rng4_next = rng3_reg;
    end

    // valid bits
    always_comb begin
        v1_next      = adv1 ? s_valid : v1_reg;
        v2_next      = adv2 ? v1_reg  : v2_reg;
        v3_next      = adv3 ? v2_reg  : v3_reg;
        m_valid_next = adv4 ? v3_reg  : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers load when their stage moves
    always_ff @(posedge aclk) begin
        if (adv1) begin
            d1_reg   <= d1_next;
            k1_reg   <= k1_next;
            rng1_reg <= rng1_next;
        end
        if (adv2) begin
            lin2_reg  <= lin2_next;
            sq2_reg   <= sq2_next;
            quad2_reg <= quad2_next;
            rng2_reg  <= rng2_next;
        end
        if (adv3) begin
            acc3_reg <= acc3_next;
            rng3_reg <= rng3_next;
        end
        if (adv4) begin
            temp_reg <= temp_next;
            rng4_reg <= rng4_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_temperature_c = temp_reg;
    assign m_in_range      = rng4_reg;

endmodule

// ===== rtl/ntc_pt_checker.sv =====
// ============================================================================
// ntc_pt_checker
// Port-level checks for the thermistor linearization block.
// ============================================================================
module ntc_pt_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [ntc_pt_pkg::RAW_W-1:0]         s_raw_sample,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [ntc_pt_pkg::TEMP_W-1:0] m_temperature_c,
    input logic                                 m_in_range
);
    import ntc_pt_pkg::*;

    // waiting sample transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_raw_sample))
        else $error("sample changed while waiting");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature_c)
                                && $stable(m_in_range))
        else $error("result changed while stalled");

    // out of range gives zero
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_temperature_c == '0)
        else $error("out-of-range transaction with nonzero temperature");

    // in range stays within the sensor span
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_range |-> m_temperature_c >= -TEMP_W'(40)
                                  && m_temperature_c <= TEMP_W'(150))
        else $error("temperature outside sensor span");

    // nothing pending right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ntc_piecewise_temperature ntc_pt_checker u_ntc_pt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_raw_sample    (s_raw_sample),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_temperature_c (m_temperature_c),
    .m_in_range      (m_in_range)
);

// ===== sim/ntc_piecewise_temperature_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ntc_piecewise_temperature_tb
// Checks the nine-segment thermistor linearization against its own Q16
// predictor. Directed samples cover range limits and every segment edge,
// the quadratic segment among them. About 500 random samples follow, mixed
// from uniform, edge-near, quadratic and out-of-range draws. Both channels
// idle and stall at random, with stretches that run without gaps.
// ============================================================================
module ntc_piecewise_temperature_tb;

    import ntc_pt_pkg::*;

    localparam int SHIFT        = 3;
    localparam int SCALED_LO    = 5;
    localparam int SCALED_HI    = 483;
    localparam int QUAD_SEGMENT = 8;
    localparam longint QUAD_Q16 = 36622;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_PRINTED  = 20;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_c;
        logic                     in_range;
    } ntc_reading_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [RAW_W-1:0]         s_raw_sample = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [TEMP_W-1:0] m_temperature_c;
    logic                     m_in_range;

    ntc_reading_t expected_readings[$];
    int           error_count = 0;
    int           in_range_checked = 0;
    int           out_of_range_checked = 0;
    int           quad_samples_sent = 0;
    int           samples_sent = 0;
    bit           tx_gaps_on = 1'b1;
    bit           rx_stalls_on = 1'b1;

    ntc_piecewise_temperature #(
        .DIVIDER_SHIFT(SHIFT)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_sample   (s_raw_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_temperature_c(m_temperature_c),
        .m_in_range     (m_in_range)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    // segment index of an in-range scaled sample, highest segment first
    function automatic int segment_of(input int unsigned d);
        if (d >= 424) return 0;
        if (d >= 316) return 1;
        if (d >= 195) return 2;
        if (d >= 107) return 3;
        if (d >= 56)  return 4;
        if (d >= 30)  return 5;
        if (d >= 17)  return 6;
        if (d >= 10)  return 7;
        return QUAD_SEGMENT;
    endfunction

    // segment slope and offset, Q16
    function automatic longint slope_q16(input int seg);
        case (seg)
            0:       return -21863;
            1:       return -11960;
            2:       return -10774;
            3:       return -14903;
            4:       return -26162;
            5:       return -50928;
            6:       return -98966;
            7:       return -190756;
            default: return -923337;
        endcase
    endfunction

    function automatic longint offset_q16(input int seg);
        case (seg)
            0:       return 8035369;
            1:       return 3813343;
            2:       return 3399221;
            3:       return 4169925;
            4:       return 5344592;
            5:       return 6716785;
            6:       return 8146125;
            7:       return 9662628;
            default: return 13413253;
        endcase
    endfunction

    // expected reading: segment fit, integer part toward zero
    function automatic ntc_reading_t predict_reading(input logic [RAW_W-1:0] raw);
        ntc_reading_t r;
        int unsigned  d;
        int           seg;
        longint       acc;
        longint       whole;
        r = '0;
        d = raw >> SHIFT;
        if (d < SCALED_LO || d > SCALED_HI) return r;
        seg = segment_of(d);
        acc = slope_q16(seg) * longint'(d) + offset_q16(seg);
        if (seg == QUAD_SEGMENT) acc += QUAD_Q16 * longint'(d) * longint'(d);
        whole = (acc >= 0) ? (acc >>> 16) : -((-acc) >>> 16);
        r.temperature_c = whole[TEMP_W-1:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one sample transaction on the s_ channel
    task automatic send_sample(input logic [RAW_W-1:0] raw);
        int gap;
        int unsigned d;
        gap = tx_gaps_on ? idle_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_raw_sample <= raw;
        do @(posedge aclk); while (!s_ready);
        expected_readings.push_back(predict_reading(raw));
        samples_sent++;
        d = raw >> SHIFT;
        if (d >= SCALED_LO && d < 10) quad_samples_sent++;
    endtask

    // raw sample from a scaled value and random low bits
    function automatic logic [RAW_W-1:0] raw_from_scaled(input int unsigned d);
        return RAW_W'((d << SHIFT) | $urandom_range(0, (1 << SHIFT) - 1));
    endfunction

    task automatic test_range_limits();
        send_sample(RAW_W'(0));
        send_sample(RAW_W'(4095));
        send_sample(RAW_W'(3871));
        send_sample(RAW_W'(3872));
        send_sample(RAW_W'(2048));
    endtask

    // last code below each segment bound and first code on it
    task automatic test_segment_edges();
        int unsigned bounds[9] = '{424, 316, 195, 107, 56, 30, 17, 10, 5};
        foreach (bounds[i]) begin
            send_sample(RAW_W'((bounds[i] << SHIFT) - 1));
            send_sample(RAW_W'(bounds[i] << SHIFT));
        end
    endtask

    task automatic test_random_samples();
        int unsigned bounds[9] = '{424, 316, 195, 107, 56, 30, 17, 10, 5};
        int          pick;
        int unsigned d;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // rotate idling modes every 50 samples
            tx_gaps_on   = ((i / 50) % 4 == 0) || ((i / 50) % 4 == 2);
            rx_stalls_on = ((i / 50) % 4 == 0) || ((i / 50) % 4 == 3);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_sample(RAW_W'($urandom_range(0, 4095)));
            end else if (pick < 80) begin
                d = bounds[$urandom_range(0, 8)] + $urandom_range(0, 2) - 1;
                send_sample(raw_from_scaled(d));
            end else if (pick < 90) begin
                send_sample(raw_from_scaled($urandom_range(SCALED_LO, 9)));
            end else if (pick < 95) begin
                send_sample(RAW_W'($urandom_range(0, (SCALED_LO << SHIFT) - 1)));
            end else begin
                send_sample(RAW_W'($urandom_range((SCALED_HI + 1) << SHIFT, 4095)));
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // result ready with random stalls
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (idle_length() + 1) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // compare each result transaction with the oldest expected reading
    always @(posedge aclk) begin
        ntc_reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected result temp %0d in_range %0b",
                                          m_temperature_c, m_in_range));
            end else begin
                want = expected_readings.pop_front();
                if (m_temperature_c !== want.temperature_c)
                    report_mismatch($sformatf("temperature_c %0d, expected %0d",
                                              m_temperature_c, want.temperature_c));
                if (m_in_range !== want.in_range)
                    report_mismatch($sformatf("in_range %0b, expected %0b",
                                              m_in_range, want.in_range));
                if (want.in_range) in_range_checked++;
                else out_of_range_checked++;
            end
        end
    end

    // test sequence
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_range_limits();
        test_segment_edges();
        test_random_samples();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        $display("covered %0d samples, %0d in the quadratic segment", samples_sent,
                 quad_samples_sent);
        $display("checked %0d in-range and %0d out-of-range readings", in_range_checked,
                 out_of_range_checked);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
